@@ sv/bdp_pkg.sv @@
package bdp_pkg;

    // AD structure types of interest
    localparam logic [7:0] TYPE_FLAGS      = 8'h01;
    localparam logic [7:0] TYPE_NAME_SHORT = 8'h08;
    localparam logic [7:0] TYPE_NAME_FULL  = 8'h09;
    localparam logic [7:0] TYPE_APPEARANCE = 8'h19;

    // Why the walk ended
    localparam logic [1:0] STOP_END      = 2'd0;
    localparam logic [1:0] STOP_ZERO_LEN = 2'd1;
    localparam logic [1:0] STOP_OVERRUN  = 2'd2;

    // Result kinds
    localparam logic KIND_NAME    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Default depth of the result queue (power of two, at least 2)
    localparam int BDP_OUT_DEPTH = 4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_byte;
        logic        name_found;
        logic [7:0]  name_length;
        logic        flags_found;
        logic [7:0]  flags_value;
        logic        appearance_found;
        logic [15:0] appearance_value;
        logic [1:0]  stop_code;
        logic        last;
    } result_t;

endpackage

@@ sv/ble_advertising_data_parser.sv @@
// BLE advertising data parser: walks an advertising report one payload byte
// per beat as a chain of length-type-value AD structures.
// Input stream (s_axis): one payload byte per beat; tuser high on the first
// byte of a report, where the report length in tdata[15:8] is taken.
// Output stream (m_axis): tuser 0 is a name character, tuser 1 is the
// end-of-report summary (flags, appearance, name length, stop reason).
// tlast marks the last result beat caused by one input beat.
// Path: an accepted byte is held in the input register, and the walk step
// writes its results into the result queue, whose head drives m_axis.
// Throughput: one input byte per cycle while the queue has room. Only the
// final byte of a report can raise two result beats (last name character
// plus summary); the output side moves one beat per cycle while m_axis_tready
// is high, so the second beat waits in the result queue.
// The walk step fires only while the queue has room for two beats; when the
// receiver stalls, the queue fills and s_axis_tready drops, holding the byte
// in the input register. Nothing is lost or repeated.
// Reset clears the walk state, the input register and the queue; the block
// is ready as soon as reset is released.
module ble_advertising_data_parser
    import bdp_pkg::*;
#(
    parameter int OUT_DEPTH = BDP_OUT_DEPTH   // power of two, 2 or more
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte[7:0], report_length[15:8]
    input  logic        s_axis_tuser,   // first_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // name_byte[7:0], name_found[8], name_length[16:9], flags_found[17],
    // flags_value[25:18], appearance_found[26], appearance_value[42:27],
    // stop_code[44:43], zero pad[47:45]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // last_result
);

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic [7:0]  in_len_reg;

    // Result queue
    result_t     queue_mem [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg,  count_next;

    logic        step_fire;
    logic        out_pop;
    logic [1:0]  res_count;
    result_t     res_a;
    result_t     res_b;
    result_t     head;

    // Step only with room for the worst case of two result beats
    assign step_fire     = in_valid_reg && (count_reg <= CNT_W'(OUT_DEPTH - 2));
    assign s_axis_tready = !in_valid_reg || step_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Payload of the input register: capture only on an accepted beat
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata[7:0];
            in_len_reg   <= s_axis_tdata[15:8];
            in_first_reg <= s_axis_tuser;
        end
    end

    bdp_walk u_walk (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step_fire),
        .data_byte     (in_byte_reg),
        .first_byte    (in_first_reg),
        .report_length (in_len_reg),
        .res_count     (res_count),
        .res_a         (res_a),
        .res_b         (res_b)
    );

    // Push up to two results in order; the second goes behind the first
    always_ff @(posedge clk)
    begin
        if (step_fire && res_count != 2'd0)
        begin
            queue_mem[wr_ptr_reg] <= res_a;
            if (res_count == 2'd2)
                queue_mem[wr_ptr_reg + PTR_W'(1)] <= res_b;
        end
    end

    assign out_pop    = m_axis_tvalid && m_axis_tready;
    assign count_next = count_reg
                      + (step_fire ? CNT_W'(res_count) : CNT_W'(0))
                      - CNT_W'(out_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (step_fire)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(res_count);
            if (out_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // Present the queue head
    assign head          = queue_mem[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != CNT_W'(0));
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {3'b000,
                            head.stop_code,
                            head.appearance_value,
                            head.appearance_found,
                            head.flags_value,
                            head.flags_found,
                            head.name_length,
                            head.name_found,
                            head.name_byte};

endmodule

@@ sv/bdp_walk.sv @@
module bdp_walk
    import bdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic [7:0] report_length,
    output logic [1:0] res_count,
    output result_t    res_a,
    output result_t    res_b
);

    localparam logic [1:0] PH_LEN   = 2'd0;
    localparam logic [1:0] PH_TYPE  = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    logic [7:0]  bytes_left_reg,  bytes_left_next;
    logic [7:0]  field_left_reg,  field_left_next;
    logic [1:0]  phase_reg,       phase_next;
    logic [1:0]  vpos_reg,        vpos_next;     // saturates at 2
    logic [7:0]  cur_type_reg,    cur_type_next;
    logic        stopped_reg,     stopped_next;
    logic [1:0]  reason_reg,      reason_next;
    logic        flags_seen_reg,  flags_seen_next;
    logic [7:0]  flags_byte_reg,  flags_byte_next;
    logic        app_seen_reg,    app_seen_next;
    logic [15:0] app_word_reg,    app_word_next;
    logic        name_seen_reg,   name_seen_next;
    logic        in_name_reg,     in_name_next;
    logic [7:0]  name_count_reg,  name_count_next;

    logic        emit_name;
    logic        emit_sum;
    logic        last_val;
    result_t     name_res;
    result_t     sum_res;

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        field_left_next = field_left_reg;
        phase_next      = phase_reg;
        vpos_next       = vpos_reg;
        cur_type_next   = cur_type_reg;
        stopped_next    = stopped_reg;
        reason_next     = reason_reg;
        flags_seen_next = flags_seen_reg;
        flags_byte_next = flags_byte_reg;
        app_seen_next   = app_seen_reg;
        app_word_next   = app_word_reg;
        name_seen_next  = name_seen_reg;
        in_name_next    = in_name_reg;
        name_count_next = name_count_reg;
        emit_name       = 1'b0;
        emit_sum        = 1'b0;
        last_val        = 1'b0;

        if (step)
        begin
            // A new report drops whatever was open
            if (first_byte)
            begin
                bytes_left_next = report_length;
                field_left_next = '0;
                phase_next      = PH_LEN;
                vpos_next       = '0;
                cur_type_next   = '0;
                stopped_next    = 1'b0;
                reason_next     = STOP_END;
                flags_seen_next = 1'b0;
                flags_byte_next = '0;
                app_seen_next   = 1'b0;
                app_word_next   = '0;
                name_seen_next  = 1'b0;
                in_name_next    = 1'b0;
                name_count_next = '0;
            end

            if (bytes_left_next != 8'd0)
            begin
                if (!stopped_next)
                begin
                    case (phase_next)
                        PH_LEN:
                        begin
                            if (data_byte == 8'd0)
                            begin
                                stopped_next = 1'b1;
                                reason_next  = STOP_ZERO_LEN;
                            end
                            else if (data_byte >= bytes_left_next)
                            begin
                                stopped_next = 1'b1;
                                reason_next  = STOP_OVERRUN;
                            end
                            else
                            begin
                                field_left_next = data_byte;
                                phase_next      = PH_TYPE;
                            end
                        end
                        PH_TYPE:
                        begin
                            cur_type_next   = data_byte;
                            field_left_next = field_left_next - 8'd1;
                            vpos_next       = '0;
                            if ((data_byte inside {TYPE_NAME_SHORT, TYPE_NAME_FULL})
                                && !name_seen_next)
                            begin
                                name_seen_next = 1'b1;
                                in_name_next   = 1'b1;
                            end
                            if (field_left_next == 8'd0)
                            begin
                                if (data_byte == TYPE_FLAGS)
                                    flags_seen_next = 1'b1;
                                if (data_byte == TYPE_APPEARANCE)
                                    app_seen_next = 1'b1;
                                in_name_next = 1'b0;
                                phase_next   = PH_LEN;
                            end
                            else
                            begin
                                phase_next = PH_VALUE;
                            end
                        end
                        default:
                        begin
                            last_val = (field_left_next == 8'd1);
                            if (cur_type_next == TYPE_FLAGS && !flags_seen_next
                                && vpos_next == 2'd0)
                                flags_byte_next = data_byte;
                            if (cur_type_next == TYPE_APPEARANCE && !app_seen_next)
                            begin
                                if (vpos_next == 2'd0)
                                    app_word_next[7:0] = data_byte;
                                else if (vpos_next == 2'd1)
                                    app_word_next[15:8] = data_byte;
                            end
                            // drop a single trailing zero of the name
                            if (in_name_next && (!last_val || data_byte != 8'd0))
                            begin
                                emit_name       = 1'b1;
                                name_count_next = name_count_next + 8'd1;
                            end
                            if (vpos_next != 2'd2)
                                vpos_next = vpos_next + 2'd1;
                            field_left_next = field_left_next - 8'd1;
                            if (last_val)
                            begin
                                if (cur_type_next == TYPE_FLAGS)
                                    flags_seen_next = 1'b1;
                                if (cur_type_next == TYPE_APPEARANCE)
                                    app_seen_next = 1'b1;
                                in_name_next = 1'b0;
                                phase_next   = PH_LEN;
                            end
                        end
                    endcase
                end

                bytes_left_next = bytes_left_next - 8'd1;
                emit_sum        = (bytes_left_next == 8'd0);
            end
        end
    end

    always_comb
    begin
        name_res           = '0;
        name_res.kind      = KIND_NAME;
        name_res.name_byte = data_byte;
        name_res.last      = !emit_sum;

        sum_res                  = '0;
        sum_res.kind             = KIND_SUMMARY;
        sum_res.name_found       = name_seen_next;
        sum_res.name_length      = name_count_next;
        sum_res.flags_found      = flags_seen_next;
        sum_res.flags_value      = flags_byte_next;
        sum_res.appearance_found = app_seen_next;
        sum_res.appearance_value = app_word_next;
        sum_res.stop_code        = stopped_next ? reason_next : STOP_END;
        sum_res.last             = 1'b1;

        res_a     = emit_name ? name_res : sum_res;
        res_b     = sum_res;
        res_count = {1'b0, emit_name} + {1'b0, emit_sum};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            field_left_reg <= '0;
            phase_reg      <= PH_LEN;
            vpos_reg       <= '0;
            cur_type_reg   <= '0;
            stopped_reg    <= 1'b0;
            reason_reg     <= STOP_END;
            flags_seen_reg <= 1'b0;
            flags_byte_reg <= '0;
            app_seen_reg   <= 1'b0;
            app_word_reg   <= '0;
            name_seen_reg  <= 1'b0;
            in_name_reg    <= 1'b0;
            name_count_reg <= '0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            field_left_reg <= field_left_next;
            phase_reg      <= phase_next;
            vpos_reg       <= vpos_next;
            cur_type_reg   <= cur_type_next;
            stopped_reg    <= stopped_next;
            reason_reg     <= reason_next;
            flags_seen_reg <= flags_seen_next;
            flags_byte_reg <= flags_byte_next;
            app_seen_reg   <= app_seen_next;
            app_word_reg   <= app_word_next;
            name_seen_reg  <= name_seen_next;
            in_name_reg    <= in_name_next;
            name_count_reg <= name_count_next;
        end
    end

endmodule
